// ----- src/cssc_pkg.sv -----
`default_nettype none

package cssc_pkg;

	// display store and font
	localparam int StoreDepth = 8;
	localparam int CodeW = 5;
	localparam int FontSize = 27;

	// time limits and time after reset
	localparam int SecLimit = 60;
	localparam int MinLimit = 60;
	localparam int HourLimit = 24;
	localparam logic [5:0] ResetSeconds = 6'd0;
	localparam logic [5:0] ResetMinutes = 6'd25;
	localparam logic [4:0] ResetHours = 5'd20;

	// command codes; code 3 means nothing
	typedef enum logic [1:0] {
		CMD_SECOND = 2'd0,
		CMD_SCAN   = 2'd1,
		CMD_LOAD   = 2'd2
	} command_t;

	typedef logic [CodeW-1:0] code_t;
	typedef code_t [StoreDepth-1:0] code_row_t;

	typedef struct packed {
		logic [1:0] command;
		code_t      code0;
		code_t      code1;
		code_t      code2;
		code_t      code3;
		code_t      code4;
		code_t      code5;
		code_t      code6;
		code_t      code7;
	} item_t;

	typedef struct packed {
		logic [7:0] segment_pattern;
		logic [7:0] digit_enable;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} result_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} clock_time_t;

	// segment font, codes above the table show blank
	function automatic logic [7:0] font_lookup(input code_t code);
		logic [7:0] pattern;
		case (code)
			5'd0:    pattern = 8'h3F;
			5'd1:    pattern = 8'h06;
			5'd2:    pattern = 8'h5B;
			5'd3:    pattern = 8'h4F;
			5'd4:    pattern = 8'h66;
			5'd5:    pattern = 8'h6D;
			5'd6:    pattern = 8'h7D;
			5'd7:    pattern = 8'h07;
			5'd8:    pattern = 8'h7F;
			5'd9:    pattern = 8'h6F;
			5'd10:   pattern = 8'h77;
			5'd11:   pattern = 8'h7C;
			5'd12:   pattern = 8'h39;
			5'd13:   pattern = 8'h5E;
			5'd14:   pattern = 8'h79;
			5'd15:   pattern = 8'h71;
			5'd16:   pattern = 8'h00;
			5'd17:   pattern = 8'h40;
			5'd18:   pattern = 8'h76;
			5'd19:   pattern = 8'h1E;
			5'd20:   pattern = 8'h70;
			5'd21:   pattern = 8'h38;
			5'd22:   pattern = 8'h37;
			5'd23:   pattern = 8'h5C;
			5'd24:   pattern = 8'h73;
			5'd25:   pattern = 8'h3E;
			5'd26:   pattern = 8'h78;
			default: pattern = 8'h00;
		endcase
		return pattern;
	endfunction

	// tens digit of a value below sixty
	function automatic code_t tens_of(input logic [5:0] value);
		code_t tens;
		if (value >= 6'd50)
			tens = 5'd5;
		else if (value >= 6'd40)
			tens = 5'd4;
		else if (value >= 6'd30)
			tens = 5'd3;
		else if (value >= 6'd20)
			tens = 5'd2;
		else if (value >= 6'd10)
			tens = 5'd1;
		else
			tens = 5'd0;
		return tens;
	endfunction

	// units digit of a value below sixty
	function automatic code_t units_of(input logic [5:0] value);
		logic [5:0] tens_x10;
		logic [5:0] units;
		tens_x10 = 6'(tens_of(value)) * 6'd10;
		units = value - tens_x10;
		return units[CodeW-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/clock_seven_segment_scanner.sv -----
// Time-of-day clock with an eight-digit multiplexed seven-segment scanner.
// Path: a word is accepted into an input register, and its result is then written
// to the result register, where it is shown and held until it is accepted.
// Throughput: one word per cycle while the result is not stalled; one short update of time, store and scan.
// Reset (arst_n, async): time 20:25:00, digit store all zero, scan on digit 0,
// no word held in either register.
`default_nettype none

module clock_seven_segment_scanner
	import cssc_pkg::*;
#(
	parameter int NUM_DIGITS = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output      logic    item_stall,
	input  wire item_t   item,
	output      logic    result_valid,
	input  wire logic    result_stall,
	output      result_t result
);

	item_t       item_s1;
	logic        valid_s1;
	result_t     result_q;
	logic        result_valid_q;
	code_row_t   codes_q;
	logic [2:0]  scan_q;

	logic        advance;
	logic        fire;
	logic        is_tick;
	logic        is_scan;
	logic        is_load;
	clock_time_t time_next;
	code_row_t   tick_codes;
	code_row_t   load_codes;
	logic [2:0]  scan_idx;
	logic [3:0]  scan_inc;
	logic [2:0]  scan_next;

	// handshake: the input register moves when the result register frees up
	assign advance = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign fire = valid_s1 && advance;
	assign is_tick = fire && (item_s1.command == CMD_SECOND);
	assign is_scan = fire && (item_s1.command == CMD_SCAN);
	assign is_load = fire && (item_s1.command == CMD_LOAD);
	assign result_valid = result_valid_q;
	assign result = result_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	cssc_timekeeper u_timekeeper (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (is_tick),
		.time_next (time_next),
		.tick_codes(tick_codes)
	);

	// load word codes in digit order
	always_comb begin
		load_codes[0] = item_s1.code0;
		load_codes[1] = item_s1.code1;
		load_codes[2] = item_s1.code2;
		load_codes[3] = item_s1.code3;
		load_codes[4] = item_s1.code4;
		load_codes[5] = item_s1.code5;
		load_codes[6] = item_s1.code6;
		load_codes[7] = item_s1.code7;
	end

	// scan position, wrapping at the digit count
	always_comb begin
		scan_idx = (4'(scan_q) >= 4'(NUM_DIGITS)) ? 3'd0 : scan_q;
		scan_inc = 4'(scan_idx) + 4'd1;
		scan_next = (scan_inc >= 4'(NUM_DIGITS)) ? 3'd0 : scan_inc[2:0];
	end

	// digit store and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
			scan_q <= 3'd0;
		end else begin
			if (is_tick)
				codes_q <= tick_codes;
			else if (is_load)
				codes_q <= load_codes;
			if (is_scan)
				scan_q <= scan_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.segment_pattern <= is_scan ? font_lookup(codes_q[scan_idx]) : 8'h00;
			result_q.digit_enable <= is_scan ? (8'd1 << scan_idx) : 8'h00;
			result_q.hours <= time_next.hours;
			result_q.minutes <= time_next.minutes;
			result_q.seconds <= time_next.seconds;
		end
	end

	scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		4'(scan_q) < 4'(NUM_DIGITS))
		else $error("scan position beyond digit count");

	enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $onehot0(result_q.digit_enable))
		else $error("digit enable not one-hot");

	scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(is_scan && NUM_DIGITS > 1) |=> (scan_q != $past(scan_q)))
		else $error("scan word did not move scan position");

	no_fire_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |-> !fire)
		else $error("word processed while result stalled");

endmodule

`default_nettype wire

// ----- src/cssc_timekeeper.sv -----
`default_nettype none

module cssc_timekeeper
	import cssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick,
	output      clock_time_t time_next,
	output      code_row_t   tick_codes
);

	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;

	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;

	// carry chain seconds -> minutes -> hours
	always_comb begin
		sec_inc = 7'(sec_q) + 7'd1;
		min_inc = 7'(min_q) + 7'd1;
		hour_inc = 6'(hour_q) + 6'd1;
		time_next.seconds = sec_q;
		time_next.minutes = min_q;
		time_next.hours = hour_q;
		if (tick) begin
			if (sec_inc >= 7'(SecLimit)) begin
				time_next.seconds = 6'd0;
				if (min_inc >= 7'(MinLimit)) begin
					time_next.minutes = 6'd0;
					if (hour_inc >= 6'(HourLimit))
						time_next.hours = 5'd0;
					else
						time_next.hours = hour_inc[4:0];
				end else begin
					time_next.minutes = min_inc[5:0];
				end
			end else begin
				time_next.seconds = sec_inc[5:0];
			end
		end
	end

	// digit codes written on a second tick
	always_comb begin
		tick_codes[0] = '0;
		tick_codes[1] = '0;
		tick_codes[2] = tens_of(6'(time_next.hours));
		tick_codes[3] = units_of(6'(time_next.hours));
		tick_codes[4] = tens_of(time_next.minutes);
		tick_codes[5] = units_of(time_next.minutes);
		tick_codes[6] = tens_of(time_next.seconds);
		tick_codes[7] = units_of(time_next.seconds);
	end

	// time registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= ResetSeconds;
			min_q <= ResetMinutes;
			hour_q <= ResetHours;
		end else if (tick) begin
			sec_q <= time_next.seconds;
			min_q <= time_next.minutes;
			hour_q <= time_next.hours;
		end
	end

	time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hour_q < 5'(HourLimit)) && (min_q < 6'(MinLimit)) && (sec_q < 6'(SecLimit)))
		else $error("time counter out of range");

	tick_moves_time: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> (sec_q != $past(sec_q)))
		else $error("second tick did not move seconds");

endmodule

`default_nettype wire
